FILE: hdl/rsat_pkg.sv
`default_nettype none
package rsat_pkg;

   localparam int SLOT_COUNT = 32;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int IDX_W      = 5;
   localparam int CMP_W      = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
   localparam int ADDR_W     = 52;
   localparam int END_W      = 53;
   localparam int HOST_W     = 48;
   localparam int HEND_W     = 54;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_G2H   = 2'd1,
      KIND_H2G   = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   // record that walks down the row of cells
   typedef struct packed {
      kind_type            kind;
      logic [IDX_W-1:0]    slot_index;
      logic [ADDR_W-1:0]   address;
      logic [END_W-1:0]    slot_end;
      logic [HOST_W-1:0]   slot_host;
      logic                slot_is_ram;
      logic                slot_valid;
      logic                have;
      logic [ADDR_W-1:0]   pick_begin;
      logic [END_W-1:0]    pick_end;
      logic [HOST_W-1:0]   pick_host;
      logic [SLOT_W-1:0]   pick_idx;
   } walk_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   translated;
      logic                hit;
      logic [IDX_W-1:0]    slot_found;
   } rsp_type;

endpackage
`default_nettype wire

FILE: hdl/rsat_if.sv
`default_nettype none
interface rsat_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  kind;
   logic [rsat_pkg::IDX_W-1:0]  slot_index;
   logic [rsat_pkg::ADDR_W-1:0] address;
   logic [rsat_pkg::END_W-1:0]  slot_end;
   logic [rsat_pkg::HOST_W-1:0] slot_host;
   logic                        slot_is_ram;
   logic                        slot_valid;

   modport source (
      output valid, kind, slot_index, address, slot_end, slot_host, slot_is_ram,
             slot_valid,
      input  ready
   );
   modport sink (
      input  valid, kind, slot_index, address, slot_end, slot_host, slot_is_ram,
             slot_valid,
      output ready
   );
endinterface

interface rsat_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [rsat_pkg::ADDR_W-1:0] translated;
   logic                        hit;
   logic [rsat_pkg::IDX_W-1:0]  slot_found;

   modport source (output valid, translated, hit, slot_found, input ready);
   modport sink   (input valid, translated, hit, slot_found, output ready);
endinterface
`default_nettype wire

FILE: hdl/rsat_cell.sv
`default_nettype none
module rsat_cell (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [rsat_pkg::SLOT_W-1:0]   cell_id,
   input  wire logic                          in_vld,
   input  wire rsat_pkg::walk_type            in_walk,
   output logic                               out_vld,
   output rsat_pkg::walk_type                 out_walk
);
   import rsat_pkg::*;

   logic [ADDR_W-1:0] e_begin_ff;
   logic [END_W-1:0]  e_end_ff;
   logic [HOST_W-1:0] e_host_ff;
   logic [HEND_W-1:0] e_hend_ff;
   logic              e_ram_ff;
   logic              e_nonempty_ff;
   logic              e_valid_ff;

   logic [HEND_W-1:0] e_hend_in;
   logic              e_nonempty_in;
   logic              wr_sel;
   logic              g2h_take;
   logic              h2g_take;

   logic              out_vld_ff;
   walk_type          out_walk_ff;
   walk_type          out_walk_in;

   assign wr_sel = in_vld && (in_walk.kind == KIND_WRITE) &&
                   (CMP_W'(in_walk.slot_index) == CMP_W'(cell_id));

   // host range end kept precomputed so the reverse match is two compares
   assign e_hend_in = HEND_W'(in_walk.slot_end) - HEND_W'(in_walk.address)
                    + HEND_W'(in_walk.slot_host);
   assign e_nonempty_in = in_walk.slot_end > END_W'(in_walk.address);

   assign g2h_take = e_valid_ff && (e_begin_ff <= in_walk.address) &&
                     (!in_walk.have || (e_begin_ff > in_walk.pick_begin));

   assign h2g_take = !in_walk.have && e_valid_ff && e_ram_ff && e_nonempty_ff &&
                     (ADDR_W'(e_host_ff) <= in_walk.address) &&
                     (HEND_W'(in_walk.address) < e_hend_ff);

   always_comb begin
      out_walk_in = in_walk;
      if (((in_walk.kind == KIND_G2H) && g2h_take) ||
          ((in_walk.kind == KIND_H2G) && h2g_take)) begin
         out_walk_in.have       = 1'b1;
         out_walk_in.pick_begin = e_begin_ff;
         out_walk_in.pick_end   = e_end_ff;
         out_walk_in.pick_host  = e_host_ff;
         out_walk_in.pick_idx   = cell_id;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_sel) begin
         e_begin_ff    <= in_walk.address;
         e_end_ff      <= in_walk.slot_end;
         e_host_ff     <= in_walk.slot_host;
         e_hend_ff     <= e_hend_in;
         e_ram_ff      <= in_walk.slot_is_ram;
         e_nonempty_ff <= e_nonempty_in;
      end
      out_walk_ff <= out_walk_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (wr_sel) begin
            e_valid_ff <= in_walk.slot_valid;
         end
         out_vld_ff <= in_vld;
      end
   end

   assign out_vld  = out_vld_ff;
   assign out_walk = out_walk_ff;

endmodule
`default_nettype wire

FILE: hdl/rsat_finish.sv
`default_nettype none
module rsat_finish (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_vld,
   input  wire rsat_pkg::walk_type in_walk,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output rsat_pkg::rsp_type       rsp_data
);
   import rsat_pkg::*;

   logic              f_vld_ff;
   logic              f_hit_ff;
   logic [ADDR_W-1:0] f_off_ff;
   logic [ADDR_W-1:0] f_base_ff;
   logic [IDX_W-1:0]  f_idx_ff;

   logic              f_hit_in;
   logic [ADDR_W-1:0] f_off_in;
   logic [ADDR_W-1:0] f_base_in;

   logic              rsp_vld_ff;
   logic              rsp_vld_in;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   always_comb begin
      f_hit_in  = 1'b0;
      f_off_in  = '0;
      f_base_in = '0;
      unique case (in_walk.kind)
         KIND_WRITE: f_hit_in = 1'b1;
         KIND_G2H: begin
            f_hit_in  = in_walk.have && (END_W'(in_walk.address) < in_walk.pick_end);
            f_off_in  = in_walk.address - in_walk.pick_begin;
            f_base_in = ADDR_W'(in_walk.pick_host);
         end
         KIND_H2G: begin
            f_hit_in  = in_walk.have;
            f_off_in  = in_walk.address - ADDR_W'(in_walk.pick_host);
            f_base_in = in_walk.pick_begin;
         end
         KIND_NONE: f_hit_in = 1'b0;
         default:   f_hit_in = 1'b0;
      endcase
   end

   // writes answer hit with zero address and index
   always_comb begin
      rsp_in.hit        = f_hit_ff;
      rsp_in.translated = '0;
      rsp_in.slot_found = '0;
      if (f_hit_ff) begin
         rsp_in.translated = f_base_ff + f_off_ff;
         rsp_in.slot_found = f_idx_ff;
      end
   end

   assign rsp_vld_in = f_vld_ff ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      f_hit_ff  <= f_hit_in;
      f_off_ff  <= f_off_in;
      f_base_ff <= f_base_in;
      f_idx_ff  <= (in_walk.kind == KIND_WRITE) ? '0 : IDX_W'(in_walk.pick_idx);
      if (f_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         f_vld_ff   <= in_vld;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: hdl/range_slot_address_translator.sv
// Path: from request acceptance to response valid, a request passes through every
// slot cell, each registered, then the two finishing stages.
// Flow: one transaction in flight; the next request is taken the cycle
// after the response is taken.
// Reset: synchronous; clears all slot valid flags and the pipeline valids.
`default_nettype none
module range_slot_address_translator (
   input  wire logic clock,
   input  wire logic reset,
   rsat_req_if.sink  req_chan,
   rsat_rsp_if.source rsp_chan
);
   import rsat_pkg::*;

   logic     busy_ff;
   logic     busy_in;
   logic     req_take;
   logic     rsp_take;

   logic     vld   [0:SLOT_COUNT];
   walk_type walk  [0:SLOT_COUNT];
   rsp_type  rsp_data;
   logic     rsp_valid;

   assign req_chan.ready = !busy_ff && !reset;
   assign req_take = req_chan.valid && !busy_ff && !reset;
   assign rsp_take = rsp_valid && rsp_chan.ready;
   assign busy_in  = req_take ? 1'b1 : (rsp_take ? 1'b0 : busy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_comb begin
      vld[0]             = req_take;
      walk[0].kind       = kind_type'(req_chan.kind);
      walk[0].slot_index = req_chan.slot_index;
      walk[0].address    = req_chan.address;
      walk[0].slot_end   = req_chan.slot_end;
      walk[0].slot_host  = req_chan.slot_host;
      walk[0].slot_is_ram = req_chan.slot_is_ram;
      walk[0].slot_valid = req_chan.slot_valid;
      walk[0].have       = 1'b0;
      walk[0].pick_begin = '0;
      walk[0].pick_end   = '0;
      walk[0].pick_host  = '0;
      walk[0].pick_idx   = '0;
   end

   for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
      rsat_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_id  (SLOT_W'(i)),
         .in_vld   (vld[i]),
         .in_walk  (walk[i]),
         .out_vld  (vld[i+1]),
         .out_walk (walk[i+1])
      );
   end

   rsat_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (vld[SLOT_COUNT]),
      .in_walk   (walk[SLOT_COUNT]),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.translated = rsp_data.translated;
   assign rsp_chan.hit        = rsp_data.hit;
   assign rsp_chan.slot_found = rsp_data.slot_found;

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps
module tb;
   import rsat_pkg::*;

   localparam int ITEM_TARGET = 1350;
   localparam int LONG_HOLD   = 300;
   localparam int DIR_ROWS    = 25;

   localparam logic [ADDR_W-1:0] A_MAX = 52'hF_FFFF_FFFF_FFFF;
   localparam logic [END_W-1:0]  E_TOP = 53'h10_0000_0000_0000;
   localparam logic [HOST_W-1:0] H_MAX = 48'hFFFF_FFFF_FFFF;

   typedef struct {
      kind_type            kind;
      logic [IDX_W-1:0]    slot_index;
      logic [ADDR_W-1:0]   address;
      logic [END_W-1:0]    slot_end;
      logic [HOST_W-1:0]   slot_host;
      logic                slot_is_ram;
      logic                slot_valid;
   } xact_type;

   typedef struct {
      kind_type            kind;
      logic [IDX_W-1:0]    slot_index;
      logic [ADDR_W-1:0]   address;
      logic [END_W-1:0]    slot_end;
      logic [HOST_W-1:0]   slot_host;
      logic                slot_is_ram;
      logic                slot_valid;
      bit                  preset;
      logic [ADDR_W-1:0]   exp_translated;
      logic                exp_hit;
      logic [IDX_W-1:0]    exp_slot;
   } dir_row_type;

   // preset rows carry the answer typed in; the rest go through the predictor
   dir_row_type dir_table [0:DIR_ROWS-1] = '{
      '{KIND_G2H,   5'd0,  52'h0, 53'h0, 48'h0, 1'b0, 1'b0, 1'b1, 52'h0, 1'b0, 5'd0},
      '{KIND_H2G,   5'd31, A_MAX, E_TOP, H_MAX, 1'b1, 1'b1, 1'b1, 52'h0, 1'b0, 5'd0},
      '{KIND_NONE,  5'd31, A_MAX, E_TOP, H_MAX, 1'b1, 1'b1, 1'b1, 52'h0, 1'b0, 5'd0},
      '{KIND_WRITE, 5'd0,  52'h0, 53'h1000, 48'h8000_0000, 1'b1, 1'b1,
        1'b1, 52'h0, 1'b1, 5'd0},
      '{KIND_G2H,   5'd0,  52'h0, 53'h0, 48'h0, 1'b0, 1'b0,
        1'b1, 52'h8000_0000, 1'b1, 5'd0},
      '{KIND_G2H,   5'd0,  52'hFFF, 53'h0, 48'h0, 1'b0, 1'b0,
        1'b1, 52'h8000_0FFF, 1'b1, 5'd0},
      '{KIND_G2H,   5'd0,  52'h1000, 53'h0, 48'h0, 1'b0, 1'b0, 1'b1, 52'h0, 1'b0, 5'd0},
      '{KIND_H2G,   5'd0,  52'h8000_0800, 53'h0, 48'h0, 1'b0, 1'b0,
        1'b1, 52'h800, 1'b1, 5'd0},
      '{KIND_H2G,   5'd0,  52'h8000_1000, 53'h0, 48'h0, 1'b0, 1'b0,
        1'b1, 52'h0, 1'b0, 5'd0},
      '{KIND_WRITE, 5'd31, 52'hF_FFFF_FFFF_FFF0, E_TOP, H_MAX, 1'b1, 1'b1,
        1'b1, 52'h0, 1'b1, 5'd0},
      '{KIND_G2H,   5'd0,  A_MAX, 53'h0, 48'h0, 1'b0, 1'b0, 1'b0, 52'h0, 1'b0, 5'd0},
      '{KIND_H2G,   5'd0,  52'hFFFF_FFFF_FFFF, 53'h0, 48'h0, 1'b0, 1'b0,
        1'b0, 52'h0, 1'b0, 5'd0},
      '{KIND_WRITE, 5'd1,  52'h1000, E_TOP, H_MAX, 1'b0, 1'b1,
        1'b1, 52'h0, 1'b1, 5'd0},
      // host + offset wraps past the top of the guest space
      '{KIND_G2H,   5'd0,  52'hF_FFFF_FFFF_FF00, 53'h0, 48'h0, 1'b0, 1'b0,
        1'b0, 52'h0, 1'b0, 5'd0},
      // slot 1 covers this host address but is not RAM
      '{KIND_H2G,   5'd0,  52'h1_0000_0000_0000, 53'h0, 48'h0, 1'b0, 1'b0,
        1'b0, 52'h0, 1'b0, 5'd0},
      '{KIND_WRITE, 5'd2,  52'h5000, 53'h4000, 48'h0, 1'b1, 1'b1,
        1'b1, 52'h0, 1'b1, 5'd0},
      '{KIND_G2H,   5'd0,  52'h5000, 53'h0, 48'h0, 1'b0, 1'b0, 1'b1, 52'h0, 1'b0, 5'd0},
      '{KIND_H2G,   5'd0,  52'h0, 53'h0, 48'h0, 1'b0, 1'b0, 1'b1, 52'h0, 1'b0, 5'd0},
      // clearing write still stores its fields but marks the slot invalid
      '{KIND_WRITE, 5'd2,  52'h5000, 53'h6000, 48'h100, 1'b1, 1'b0,
        1'b1, 52'h0, 1'b1, 5'd0},
      '{KIND_G2H,   5'd0,  52'h5000, 53'h0, 48'h0, 1'b0, 1'b0, 1'b0, 52'h0, 1'b0, 5'd0},
      '{KIND_H2G,   5'd0,  52'h100, 53'h0, 48'h0, 1'b0, 1'b0, 1'b1, 52'h0, 1'b0, 5'd0},
      '{KIND_WRITE, 5'd3,  52'h0, 53'h2000, 48'h10, 1'b1, 1'b1,
        1'b1, 52'h0, 1'b1, 5'd0},
      // equal begins: lowest index wins
      '{KIND_G2H,   5'd0,  52'h10, 53'h0, 48'h0, 1'b0, 1'b0, 1'b0, 52'h0, 1'b0, 5'd0},
      '{KIND_H2G,   5'd0,  52'h10, 53'h0, 48'h0, 1'b0, 1'b0, 1'b0, 52'h0, 1'b0, 5'd0},
      // overlap: greatest begin wins even though slot 3 covers it
      '{KIND_G2H,   5'd0,  52'h1800, 53'h0, 48'h0, 1'b0, 1'b0, 1'b0, 52'h0, 1'b0, 5'd0}
   };

   logic clock;
   logic reset;

   rsat_req_if req ();
   rsat_rsp_if rsp ();

   range_slot_address_translator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   // predictor copy of the slot table
   logic [ADDR_W-1:0] tab_begin [SLOT_COUNT];
   logic [END_W-1:0]  tab_end   [SLOT_COUNT];
   logic [HOST_W-1:0] tab_host  [SLOT_COUNT];
   logic              tab_ram   [SLOT_COUNT];
   logic              tab_valid [SLOT_COUNT];

   // layout planned for the current phase
   logic [63:0] lay_begin [SLOT_COUNT];
   logic [63:0] lay_end   [SLOT_COUNT];
   logic [63:0] lay_host  [SLOT_COUNT];

   rsp_type translations_due [$];
   int      mismatch_count = 0;
   bit      idle_off_send  = 1'b0;
   bit      idle_off_recv  = 1'b0;
   bit      long_hold_due  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_500_000;
      $display("range_slot_address_translator: mismatch");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [63:0] rand_below(input logic [63:0] n);
      if (n == 0) return 64'd0;
      return rand64() % n;
   endfunction

   function automatic int draw_wait(input bit quiet);
      return quiet ? 0 : int'($urandom_range(0, 19));
   endfunction

   function automatic rsp_type predict_translation(input xact_type x);
      rsp_type     r;
      bit          have;
      int          pick;
      logic [63:0] addr, size, off, sum;
      r    = '0;
      have = 1'b0;
      pick = 0;
      addr = 64'(x.address);
      case (x.kind)
         KIND_WRITE: begin
            if (int'(x.slot_index) < SLOT_COUNT) begin
               tab_begin[x.slot_index] = x.address;
               tab_end[x.slot_index]   = x.slot_end;
               tab_host[x.slot_index]  = x.slot_host;
               tab_ram[x.slot_index]   = x.slot_is_ram;
               tab_valid[x.slot_index] = x.slot_valid;
            end
            r.hit = 1'b1;
         end
         KIND_G2H: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (tab_valid[i] && 64'(tab_begin[i]) <= addr) begin
                  if (!have || tab_begin[i] > tab_begin[pick]) begin
                     have = 1'b1;
                     pick = i;
                  end
               end
            end
            if (have && addr < 64'(tab_end[pick])) begin
               off = addr - 64'(tab_begin[pick]);
               sum = 64'(tab_host[pick]) + off;
               r.translated = sum[ADDR_W-1:0];
               r.hit        = 1'b1;
               r.slot_found = IDX_W'(pick);
            end
         end
         KIND_H2G: begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!have && tab_valid[i] && tab_ram[i] &&
                   64'(tab_end[i]) > 64'(tab_begin[i]) && addr >= 64'(tab_host[i])) begin
                  size = 64'(tab_end[i]) - 64'(tab_begin[i]);
                  off  = addr - 64'(tab_host[i]);
                  if (off < size) begin
                     have         = 1'b1;
                     sum          = 64'(tab_begin[i]) + off;
                     r.translated = sum[ADDR_W-1:0];
                     r.hit        = 1'b1;
                     r.slot_found = IDX_W'(i);
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic xact_type random_xact();
      xact_type    x;
      logic [63:0] v;
      v             = rand64();
      x.kind        = kind_type'(v[1:0]);
      x.slot_index  = v[6:2];
      x.slot_is_ram = v[7];
      x.slot_valid  = v[8];
      x.address     = ADDR_W'(rand64());
      x.slot_end    = ($urandom_range(0, 7) == 0) ? E_TOP : END_W'(rand64() & 64'(A_MAX));
      x.slot_host   = HOST_W'(rand64());
      return x;
   endfunction

   // mostly lookups aimed at slot edges and interiors, with some noise
   function automatic xact_type next_lookup();
      xact_type    x;
      int          j, r;
      logic [63:0] span, off;
      x    = random_xact();
      j    = $urandom_range(0, SLOT_COUNT - 1);
      span = (lay_end[j] > lay_begin[j]) ? lay_end[j] - lay_begin[j] : 64'd0;
      case ($urandom_range(0, 4))
         0: off = 64'd0;
         1: off = span - 64'd1;
         2: off = span;
         3: off = '1;
         default: off = rand_below(span);
      endcase
      r = $urandom_range(0, 99);
      if (r < 45) begin
         x.kind    = KIND_G2H;
         x.address = ADDR_W'(lay_begin[j] + off);
      end else if (r < 75) begin
         x.kind    = KIND_H2G;
         x.address = ADDR_W'(lay_host[j] + off);
      end else if (r < 85) begin
         x.kind = ($urandom_range(0, 1) == 0) ? KIND_G2H : KIND_H2G;
      end else if (r < 90) begin
         x.kind = KIND_NONE;
      end else begin
         x.kind = KIND_WRITE;
      end
      return x;
   endfunction

   task automatic plan_layout(input int mode);
      logic [63:0] gap_len [SLOT_COUNT];
      logic [63:0] span, room, cursor;
      span = 64'd0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         case ($urandom_range(0, 9))
            0: lay_end[i] = 64'd0;
            1: lay_end[i] = 64'($urandom) << $urandom_range(0, 12);
            default: lay_end[i] = 64'($urandom_range(1, 4096));
         endcase
         gap_len[i] = ($urandom_range(0, 1) == 0) ? 64'd0 : 64'($urandom_range(1, 65536));
         span += gap_len[i] + lay_end[i];
      end
      room = 64'(E_TOP) - span;
      case (mode)
         0: cursor = 64'd0;
         1: cursor = room;
         default: cursor = rand_below(room + 64'd1);
      endcase
      for (int i = 0; i < SLOT_COUNT; i++) begin
         cursor      += gap_len[i];
         lay_begin[i] = cursor;
         cursor      += lay_end[i];
         lay_end[i]   = cursor;
         if ($urandom_range(0, 19) == 0) lay_end[i] = lay_begin[i] >> 1;
         if (i > 0 && $urandom_range(0, 5) == 0) lay_host[i] = lay_host[i-1];
         else lay_host[i] = rand64() & 64'(H_MAX);
      end
   endtask

   task automatic send_xact(input xact_type x, input bit preset, input rsp_type answer);
      int      gap;
      rsp_type due;
      gap = draw_wait(idle_off_send);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.kind        <= x.kind;
      req.slot_index  <= x.slot_index;
      req.address     <= x.address;
      req.slot_end    <= x.slot_end;
      req.slot_host   <= x.slot_host;
      req.slot_is_ram <= x.slot_is_ram;
      req.slot_valid  <= x.slot_valid;
      do @(posedge clock); while (!req.ready);
      due = predict_translation(x);
      translations_due = {translations_due, (preset ? answer : due)};
   endtask

   task automatic wait_for_drain();
      req.valid <= 1'b0;
      do @(posedge clock); while (translations_due.size() != 0);
   endtask

   initial begin : stimulus
      xact_type x;
      rsp_type  answer;
      int       random_sent, phase, lookups;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         tab_begin[i] = '0;
         tab_end[i]   = '0;
         tab_host[i]  = '0;
         tab_ram[i]   = 1'b0;
         tab_valid[i] = 1'b0;
      end
      reset           <= 1'b1;
      req.valid       <= 1'b0;
      req.kind        <= KIND_WRITE;
      req.slot_index  <= '0;
      req.address     <= '0;
      req.slot_end    <= '0;
      req.slot_host   <= '0;
      req.slot_is_ram <= 1'b0;
      req.slot_valid  <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int n = 0; n < DIR_ROWS; n++) begin
         x.kind        = dir_table[n].kind;
         x.slot_index  = dir_table[n].slot_index;
         x.address     = dir_table[n].address;
         x.slot_end    = dir_table[n].slot_end;
         x.slot_host   = dir_table[n].slot_host;
         x.slot_is_ram = dir_table[n].slot_is_ram;
         x.slot_valid  = dir_table[n].slot_valid;
         answer.translated = dir_table[n].exp_translated;
         answer.hit        = dir_table[n].exp_hit;
         answer.slot_found = dir_table[n].exp_slot;
         send_xact(x, dir_table[n].preset, answer);
      end

      random_sent = 0;
      phase       = 0;
      answer      = '0;
      while (random_sent < ITEM_TARGET) begin
         idle_off_send = ($urandom_range(0, 4) == 0);
         idle_off_recv = ($urandom_range(0, 4) == 0);
         // receiver goes quiet while the sender keeps offering
         if (phase == 1) long_hold_due = 1'b1;
         plan_layout(phase % 4);
         for (int i = 0; i < SLOT_COUNT; i++) begin
            x             = random_xact();
            x.kind        = KIND_WRITE;
            x.slot_index  = IDX_W'(i);
            x.address     = ADDR_W'(lay_begin[i]);
            x.slot_end    = END_W'(lay_end[i]);
            x.slot_host   = HOST_W'(lay_host[i]);
            x.slot_valid  = ($urandom_range(0, 5) != 0);
            x.slot_is_ram = ($urandom_range(0, 2) != 0);
            send_xact(x, 1'b0, answer);
            random_sent++;
         end
         lookups = $urandom_range(30, 80);
         repeat (lookups) begin
            x = next_lookup();
            send_xact(x, 1'b0, answer);
            if (x.kind != KIND_NONE) random_sent++;
         end
         if (phase == 3 || $urandom_range(0, 5) == 0) wait_for_drain();
         phase++;
      end

      wait_for_drain();
      repeat (SLOT_COUNT + 8) @(posedge clock);
      if (mismatch_count == 0 && translations_due.size() == 0) begin
         $display("range_slot_address_translator: match");
      end else begin
         $display("range_slot_address_translator: mismatch");
      end
      $finish;
   end

   initial begin : collect
      int      stall;
      rsp_type want;
      rsp.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold_due) begin
            long_hold_due = 1'b0;
            stall         = LONG_HOLD;
         end else begin
            stall = draw_wait(idle_off_recv);
         end
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         if (translations_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: transaction with nothing expected: translated %h hit %b slot %0d",
                     $time, rsp.translated, rsp.hit, rsp.slot_found);
         end else begin
            want = translations_due.pop_front();
            if (rsp.translated !== want.translated) begin
               mismatch_count++;
               $display("%0t: translated expected %h actual %h",
                        $time, want.translated, rsp.translated);
            end
            if (rsp.hit !== want.hit) begin
               mismatch_count++;
               $display("%0t: hit expected %b actual %b", $time, want.hit, rsp.hit);
            end
            if (rsp.slot_found !== want.slot_found) begin
               mismatch_count++;
               $display("%0t: slot_found expected %0d actual %0d",
                        $time, want.slot_found, rsp.slot_found);
            end
         end
      end
   end

endmodule
